// File: hw/rtl/sbo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbo_pkg
// Shared types and constants of the segment boundary overlay unit.
// ----------------------------------------------------------------------------
package sbo_pkg;

    localparam int unsigned FW_W  = 11;   // frame_width register
    localparam int unsigned FH_W  = 13;   // frame_height register
    localparam int unsigned ROW_W = 14;   // row counter, holds height + 1
    localparam int unsigned PIX_W = 8;
    localparam int unsigned LBL_W = 2;
    localparam int unsigned APB_AW = 3;
    localparam int unsigned APB_DW = 32;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    // register index, taken from paddr[2]
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // command field
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // segmentation labels and their compact codes
    localparam logic [PIX_W-1:0] LABEL_LOW_VAL  = 8'd100;
    localparam logic [PIX_W-1:0] LABEL_HIGH_VAL = 8'd200;
    localparam logic [PIX_W-1:0] PIX_FULL       = 8'd255;

    localparam logic [LBL_W-1:0] LBL_OTHER = 2'd0;
    localparam logic [LBL_W-1:0] LBL_LOW   = 2'd1;
    localparam logic [LBL_W-1:0] LBL_HIGH  = 2'd2;

    // one line buffer entry: labels of the two rows above and delayed grey
    typedef struct packed {
        logic [LBL_W-1:0] two_above;
        logic [LBL_W-1:0] above;
        logic [PIX_W-1:0] grey;
    } t_line_entry;

    // window edges that fall outside the frame for the pixel being finished
    typedef struct packed {
        logic top;
        logic bot;
        logic left;
        logic right;
    } t_edge_mask;

    typedef logic [LBL_W-1:0] t_win [3][3];

endpackage

// File: hw/rtl/sbo_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbo_in_if / sbo_out_if
// Valid/ready channels of the segment boundary overlay unit.
// ----------------------------------------------------------------------------
interface sbo_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] grey_value;
    logic [7:0] segment_label;

    modport source (output valid, command, grey_value, segment_label, input ready);
    modport sink   (input valid, command, grey_value, segment_label, output ready);
endinterface

interface sbo_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_last;

    modport source (output valid, red, green, blue, frame_last, input ready);
    modport sink   (input valid, red, green, blue, frame_last, output ready);
endinterface

// File: hw/rtl/sbo_line_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbo_line_mem
// Line buffer RAM: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sbo_line_mem
    import sbo_pkg::*;
#(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_line_entry   o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_line_entry   i_wr_data
);

    t_line_entry r_mem [DEPTH];
    t_line_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/segment_boundary_overlay_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_boundary_overlay_unit
// Marks region boundaries of a two-label segmentation over a grey image.
// ----------------------------------------------------------------------------
// Takes one transfer per clock and returns one result per clock when the
// output side keeps ready high; the result for pixel (r, c) is released by
// the transfer one row plus one pixel later and then passes the work stage
// and output register, so frame_width + 1 flush transfers drain a frame.
// The rate is set by the single line buffer RAM of MAX_LINE_WIDTH entries
// (labels of two rows plus one row of grey), read and written once per
// cycle; a write and a read of the same column in the same cycle are
// forwarded. Flush transfers inside a frame are dropped, pixels after a
// frame's end act as flushes. Writing frame_width or frame_height
// restarts the frame and must only happen while the unit is idle.
// ----------------------------------------------------------------------------
module segment_boundary_overlay_unit
    import sbo_pkg::*;
#(
    parameter int unsigned MAX_LINE_WIDTH = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sbo_in_if.sink            i_in,
    sbo_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int unsigned CW = $clog2(MAX_LINE_WIDTH);
    localparam int unsigned WW = $clog2(MAX_LINE_WIDTH + 1);
    localparam logic [ROW_W-1:0] MAX_W_EXT = ROW_W'(MAX_LINE_WIDTH);
    localparam logic [ROW_W-1:0] MIN_W_EXT = ROW_W'(2);
    localparam logic [FH_W-1:0]  MIN_H     = FH_W'(2);

    // configuration
    logic [FW_W-1:0]  r_frame_width;
    logic [FH_W-1:0]  r_frame_height;
    logic             cfg_wr;
    logic [ROW_W-1:0] w_ext;
    logic [WW-1:0]    w_eff;
    logic [FH_W-1:0]  h_eff;
    logic [ROW_W-1:0] h_ext;
    logic [ROW_W-1:0] h_p1;

    // input side
    logic [CW-1:0]    r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic             in_ready;
    logic             in_xfer;
    logic             is_cmd;
    logic             row_in_frame;
    logic             take;
    logic             col0;
    logic [WW-1:0]    col_p1;
    logic [LBL_W-1:0] in_label;
    logic             acc_last;

    // work stage
    logic             r_b_valid;
    logic [CW-1:0]    r_b_addr;
    logic [LBL_W-1:0] r_b_label;
    logic [PIX_W-1:0] r_b_grey;
    logic             r_b_has_out;
    logic             r_b_last;
    t_edge_mask       r_b_mask;
    logic             r_b_fwd;
    t_line_entry      r_b_fwd_data;
    logic             b_go;
    t_line_entry      rd_data;
    t_line_entry      line;
    t_line_entry      wr_data;
    t_win             r_win, n_win;
    logic [PIX_W-1:0] r_grey_hold;
    logic             int_hi, int_lo;

    // output register
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_red, r_out_green, r_out_blue;
    logic             r_out_last;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_FRAME_WIDTH) begin
                r_frame_width <= pwdata[FW_W-1:0];
            end else begin
                r_frame_height <= pwdata[FH_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_FRAME_HEIGHT) begin
            prdata = APB_DW'(r_frame_height);
        end else begin
            prdata = APB_DW'(r_frame_width);
        end
    end

    always_comb begin
        w_ext = ROW_W'(r_frame_width);
        if (w_ext < MIN_W_EXT) begin
            w_ext = MIN_W_EXT;
        end else if (w_ext > MAX_W_EXT) begin
            w_ext = MAX_W_EXT;
        end
    end

    assign w_eff = w_ext[WW-1:0];
    assign h_eff = (r_frame_height < MIN_H) ? MIN_H : r_frame_height;
    assign h_ext = ROW_W'(h_eff);
    assign h_p1  = h_ext + ROW_W'(1);

    // ---------------- input side and raster position ----------------
    assign b_go     = r_b_valid && (!r_b_has_out || !r_out_valid || o_out.ready);
    assign in_ready = !r_b_valid || b_go;
    assign i_in.ready = in_ready;

    assign in_xfer      = i_in.valid && in_ready;
    assign is_cmd       = i_in.command == CMD_FLUSH;
    assign row_in_frame = r_row < h_ext;
    assign take         = in_xfer && !(is_cmd && row_in_frame);
    assign col0         = r_col == '0;
    assign col_p1       = WW'(r_col) + WW'(1);
    assign acc_last     = col0 && (r_row == h_p1);

    always_comb begin
        in_label = LBL_OTHER;
        if (!is_cmd && row_in_frame) begin
            if (i_in.segment_label == LABEL_HIGH_VAL) begin
                in_label = LBL_HIGH;
            end else if (i_in.segment_label == LABEL_LOW_VAL) begin
                in_label = LBL_LOW;
            end
        end
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (cfg_wr) begin
            n_col = '0;
            n_row = '0;
        end else if (take) begin
            if (acc_last) begin
                n_col = '0;
                n_row = '0;
            end else if (col_p1 >= w_eff) begin
                n_col = '0;
                n_row = r_row + ROW_W'(1);
            end else begin
                n_col = col_p1[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ---------------- work stage ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (take) begin
            r_b_valid <= 1'b1;
        end else if (b_go) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_b_addr       <= r_col;
            r_b_label      <= in_label;
            r_b_grey       <= row_in_frame && !is_cmd ? i_in.grey_value : '0;
            r_b_has_out    <= (r_row >= ROW_W'(2)) || (r_row == ROW_W'(1) && !col0);
            r_b_last       <= acc_last;
            r_b_mask.top   <= col0 ? (r_row == ROW_W'(2)) : (r_row == ROW_W'(1));
            r_b_mask.bot   <= col0 ? (r_row >= h_p1) : (r_row >= h_ext);
            r_b_mask.left  <= r_col == CW'(1);
            r_b_mask.right <= col0;
            r_b_fwd        <= b_go && (r_b_addr == r_col);
            r_b_fwd_data   <= wr_data;
        end
    end

    sbo_line_mem #(
        .DEPTH (MAX_LINE_WIDTH),
        .AW    (CW)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (take),
        .i_rd_addr (r_col),
        .o_rd_data (rd_data),
        .i_wr_en   (b_go),
        .i_wr_addr (r_b_addr),
        .i_wr_data (wr_data)
    );

    assign line = r_b_fwd ? r_b_fwd_data : rd_data;

    always_comb begin
        wr_data.two_above = line.above;
        wr_data.above     = r_b_label;
        wr_data.grey      = r_b_grey;
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_win[k][0] = r_win[k][1];
            n_win[k][1] = r_win[k][2];
        end
        n_win[0][2] = line.two_above;
        n_win[1][2] = line.above;
        n_win[2][2] = r_b_label;
    end

    always_comb begin
        logic skip;
        int_hi = 1'b1;
        int_lo = 1'b1;
        for (int dr = 0; dr < 3; dr++) begin
            for (int dc = 0; dc < 3; dc++) begin
                skip = (dr == 1 && dc == 1) || (dr == 0 && r_b_mask.top)
                    || (dr == 2 && r_b_mask.bot) || (dc == 0 && r_b_mask.left)
                    || (dc == 2 && r_b_mask.right);
                if (!skip) begin
                    if (n_win[dr][dc] != LBL_HIGH) begin
                        int_hi = 1'b0;
                    end
                    if (n_win[dr][dc] != LBL_LOW) begin
                        int_lo = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= LBL_OTHER;
                end
            end
            r_grey_hold <= '0;
        end else if (b_go) begin
            r_win       <= n_win;
            r_grey_hold <= line.grey;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (b_go && r_b_has_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_go && r_b_has_out) begin
            r_out_red   <= (int_hi || int_lo) ? r_grey_hold : '0;
            r_out_green <= (int_hi || int_lo) ? r_grey_hold : '0;
            r_out_blue  <= (int_hi || int_lo) ? r_grey_hold : PIX_FULL;
            r_out_last  <= r_b_last;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.red        = r_out_red;
    assign o_out.green      = r_out_green;
    assign o_out.blue       = r_out_blue;
    assign o_out.frame_last = r_out_last;

endmodule

// File: hw/rtl/sbo_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbo_checker
// Port-level checks of the segment boundary overlay unit.
// ----------------------------------------------------------------------------
module sbo_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [24:0] i_out_data
);

    logic in_xfer;

    assign in_xfer = i_in_valid && i_in_ready;

    // no result survives reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // an empty output register never back-pressures the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

    // a new result always follows an input transfer that releases it
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(in_xfer, 2))
        else $error("result without input transfer");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed");

endmodule

bind segment_boundary_overlay_unit sbo_checker u_sbo_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  ({o_out.red, o_out.green, o_out.blue, o_out.frame_last})
);
